// File: hdl/stt_pkg.sv
// shared constants for the software timer table
// status codes, command codes, field widths and stream packing widths
// no dependencies
package stt_pkg;

    localparam int SLOT_COUNT = 8;
    localparam int SLOT_IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    localparam int TIME_W   = 32;
    localparam int ID_W     = 8;
    localparam int SLOT_W   = 4;
    localparam int STATUS_W = 2;

    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 16;

    localparam logic [STATUS_W-1:0] ST_FIRED  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ACCEPT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_REJECT = 2'd2;

    localparam logic CMD_TICK   = 1'b0;
    localparam logic CMD_CREATE = 1'b1;

endpackage

// File: hdl/software_timer_table.sv
// software timer table: slot table, shared 32-bit adder and compare, scan sequencer
// depends on stt_pkg
//
// A create request stores a timer in the lowest free slot and answers with one
// result (accepted, or rejected for event id 0 or a full table). An accepted create
// uses the one 32-bit adder twice for now + period + offset, through the create
// state. Either result waits in the pending register, and the next request is
// taken once it has moved on to the output register. A tick request advances the
// millisecond time and then visits one slot per cycle, unless a due slot meets a
// pending result and a full output register. It holds the input for the whole
// scan, and when a slot fires also while the last result moves to the output
// register. Stalls on the result side lengthen the hold. Each due slot gives one
// fired result, and the last result of a request carries tlast. The block takes no
// request while a request is in work or a result of it is still held inside.
module software_timer_table (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // event_id[7:0], period_ticks[39:8], start_offset[71:40], single_shot[72]
    input  logic [stt_pkg::S_TDATA_W-1:0]  s_tdata,
    // command[0]
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // slot[3:0], fired_id[11:4]
    output logic [stt_pkg::M_TDATA_W-1:0]  m_tdata,
    // status[1:0]
    output logic [stt_pkg::STATUS_W-1:0]   m_tuser,
    output logic                           m_tlast
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_CREATE = 2'd1;
    localparam logic [1:0] S_SCAN   = 2'd2;

    logic [1:0] state_reg, state_next;

    logic [stt_pkg::TIME_W-1:0]     now_ticks_reg, now_ticks_next;
    logic [stt_pkg::SLOT_COUNT-1:0] slot_used_reg;
    logic [stt_pkg::TIME_W-1:0]     slot_period_reg   [stt_pkg::SLOT_COUNT];
    logic [stt_pkg::TIME_W-1:0]     slot_deadline_reg [stt_pkg::SLOT_COUNT];
    logic                           slot_once_reg     [stt_pkg::SLOT_COUNT];
    logic [stt_pkg::ID_W-1:0]       slot_event_reg    [stt_pkg::SLOT_COUNT];

    logic [stt_pkg::TIME_W-1:0]     sum_reg, sum_next;
    logic [stt_pkg::TIME_W-1:0]     offset_reg, offset_next;
    logic [stt_pkg::SLOT_IDX_W-1:0] alloc_reg, alloc_next;
    logic [stt_pkg::SLOT_IDX_W-1:0] scan_idx_reg, scan_idx_next;

    logic                         pend_valid_reg, pend_valid_next;
    logic [stt_pkg::STATUS_W-1:0] pend_status_reg, pend_status_next;
    logic [stt_pkg::SLOT_W-1:0]   pend_slot_reg, pend_slot_next;
    logic [stt_pkg::ID_W-1:0]     pend_id_reg, pend_id_next;

    logic                         m_tvalid_reg, m_tvalid_next;
    logic [stt_pkg::STATUS_W-1:0] m_status_reg, m_status_next;
    logic [stt_pkg::SLOT_W-1:0]   m_slot_reg, m_slot_next;
    logic [stt_pkg::ID_W-1:0]     m_id_reg, m_id_next;
    logic                         m_last_reg, m_last_next;

    logic                         in_cmd;
    logic [stt_pkg::ID_W-1:0]     in_id;
    logic [stt_pkg::TIME_W-1:0]   in_period;
    logic [stt_pkg::TIME_W-1:0]   in_offset;
    logic                         in_once;

    logic                           free_found;
    logic [stt_pkg::SLOT_IDX_W-1:0] free_idx;
    logic [stt_pkg::TIME_W-1:0]     add_a, add_b, add_sum;
    logic                           s_acc, create_ok, due, scan_end, out_free, scan_step;

    assign in_cmd    = s_tuser;
    assign in_id     = s_tdata[7:0];
    assign in_period = s_tdata[39:8];
    assign in_offset = s_tdata[71:40];
    assign in_once   = s_tdata[72];

    assign s_tready  = (state_reg == S_IDLE) && !pend_valid_reg;
    assign s_acc     = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;

    // lowest free slot
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = stt_pkg::SLOT_COUNT - 1; i >= 0; i--) begin
            if (!slot_used_reg[i]) begin
                free_found = 1'b1;
                free_idx   = stt_pkg::SLOT_IDX_W'(i);
            end
        end
    end

    assign create_ok = (in_cmd == stt_pkg::CMD_CREATE) && (in_id != '0) && free_found;

    // shared adder
    always_comb begin
        unique case (state_reg)
            S_CREATE: begin
                add_a = sum_reg;
                add_b = offset_reg;
            end
            S_SCAN: begin
                add_a = now_ticks_reg;
                add_b = slot_period_reg[scan_idx_reg];
            end
            default: begin
                add_a = now_ticks_reg;
                add_b = (in_cmd == stt_pkg::CMD_CREATE) ? in_period : stt_pkg::TIME_W'(1);
            end
        endcase
        add_sum = add_a + add_b;
    end

    // shared compare
    assign due       = slot_used_reg[scan_idx_reg]
                       && (slot_deadline_reg[scan_idx_reg] <= now_ticks_reg);
    assign scan_end  = (scan_idx_reg == stt_pkg::SLOT_IDX_W'(stt_pkg::SLOT_COUNT - 1));
    assign scan_step = (state_reg == S_SCAN) && (!due || !pend_valid_reg || out_free);

    always_comb begin
        state_next       = state_reg;
        now_ticks_next   = now_ticks_reg;
        sum_next         = sum_reg;
        offset_next      = offset_reg;
        alloc_next       = alloc_reg;
        scan_idx_next    = scan_idx_reg;
        pend_valid_next  = pend_valid_reg;
        pend_status_next = pend_status_reg;
        pend_slot_next   = pend_slot_reg;
        pend_id_next     = pend_id_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        m_status_next    = m_status_reg;
        m_slot_next      = m_slot_reg;
        m_id_next        = m_id_reg;
        m_last_next      = m_last_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (pend_valid_reg && out_free) begin
                    m_tvalid_next   = 1'b1;
                    m_status_next   = pend_status_reg;
                    m_slot_next     = pend_slot_reg;
                    m_id_next       = pend_id_reg;
                    m_last_next     = 1'b1;
                    pend_valid_next = 1'b0;
                end
                if (s_acc) begin
                    if (in_cmd == stt_pkg::CMD_CREATE) begin
                        if (create_ok) begin
                            sum_next    = add_sum;
                            offset_next = in_offset;
                            alloc_next  = free_idx;
                            state_next  = S_CREATE;
                        end else begin
                            pend_valid_next  = 1'b1;
                            pend_status_next = stt_pkg::ST_REJECT;
                            pend_slot_next   = '0;
                            pend_id_next     = in_id;
                        end
                    end else begin
                        now_ticks_next = add_sum;
                        scan_idx_next  = '0;
                        state_next     = S_SCAN;
                    end
                end
            end
            S_CREATE: begin
                pend_valid_next  = 1'b1;
                pend_status_next = stt_pkg::ST_ACCEPT;
                pend_slot_next   = stt_pkg::SLOT_W'(alloc_reg);
                pend_id_next     = slot_event_reg[alloc_reg];
                state_next       = S_IDLE;
            end
            S_SCAN: begin
                if (scan_step) begin
                    if (due) begin
                        if (pend_valid_reg) begin
                            m_tvalid_next = 1'b1;
                            m_status_next = pend_status_reg;
                            m_slot_next   = pend_slot_reg;
                            m_id_next     = pend_id_reg;
                            m_last_next   = 1'b0;
                        end
                        pend_valid_next  = 1'b1;
                        pend_status_next = stt_pkg::ST_FIRED;
                        pend_slot_next   = stt_pkg::SLOT_W'(scan_idx_reg);
                        pend_id_next     = slot_event_reg[scan_idx_reg];
                    end
                    if (scan_end) begin
                        state_next = S_IDLE;
                    end else begin
                        scan_idx_next = scan_idx_reg + stt_pkg::SLOT_IDX_W'(1);
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            now_ticks_reg  <= '0;
            slot_used_reg  <= '0;
            pend_valid_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            now_ticks_reg  <= now_ticks_next;
            pend_valid_reg <= pend_valid_next;
            m_tvalid_reg   <= m_tvalid_next;
            if (state_reg == S_IDLE && s_acc && create_ok) begin
                slot_used_reg[free_idx] <= 1'b1;
            end
            if (scan_step && due && slot_once_reg[scan_idx_reg]) begin
                slot_used_reg[scan_idx_reg] <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        sum_reg         <= sum_next;
        offset_reg      <= offset_next;
        alloc_reg       <= alloc_next;
        scan_idx_reg    <= scan_idx_next;
        pend_status_reg <= pend_status_next;
        pend_slot_reg   <= pend_slot_next;
        pend_id_reg     <= pend_id_next;
        m_status_reg    <= m_status_next;
        m_slot_reg      <= m_slot_next;
        m_id_reg        <= m_id_next;
        m_last_reg      <= m_last_next;
        if (state_reg == S_IDLE && s_acc && create_ok) begin
            slot_period_reg[free_idx] <= in_period;
            slot_once_reg[free_idx]   <= in_once;
            slot_event_reg[free_idx]  <= in_id;
        end
        if (state_reg == S_CREATE) begin
            slot_deadline_reg[alloc_reg] <= add_sum;
        end
        if (scan_step && due && !slot_once_reg[scan_idx_reg]) begin
            slot_deadline_reg[scan_idx_reg] <= add_sum;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {{(stt_pkg::M_TDATA_W - stt_pkg::ID_W - stt_pkg::SLOT_W){1'b0}},
                       m_id_reg, m_slot_reg};

    // a result without tlast always has a follower held inside
    a_not_last_has_next: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && !m_last_reg |-> pend_valid_reg)
        else $error("non-final result shown with nothing pending");

    // time only moves on an accepted tick
    a_time_held: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != S_IDLE |=> $stable(now_ticks_reg))
        else $error("time changed during a request");

    // a tick starts the scan at the first slot
    a_tick_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && (in_cmd == stt_pkg::CMD_TICK) |=> (state_reg == S_SCAN) && (scan_idx_reg == '0))
        else $error("tick did not start the scan");

    // the create step never overwrites a held result
    a_create_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_CREATE |-> !pend_valid_reg)
        else $error("create step with a result still pending");

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps
// self-checking testbench for software_timer_table: stream requests in, timer results out
// keeps its own model of the slot table and checks every result in order
// depends on stt_pkg and software_timer_table
module testbench;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 310;
    localparam int HOLD_CYCLES  = 300;

    typedef struct packed {
        logic [stt_pkg::STATUS_W-1:0] status;
        logic [stt_pkg::SLOT_W-1:0]   slot;
        logic [stt_pkg::ID_W-1:0]     fired_id;
        logic                         last;
    } timer_result_t;

    class timer_table_scoreboard_t;
        logic [stt_pkg::TIME_W-1:0] now_ms;
        bit                         slot_used [stt_pkg::SLOT_COUNT];
        logic [stt_pkg::TIME_W-1:0] slot_period [stt_pkg::SLOT_COUNT];
        logic [stt_pkg::TIME_W-1:0] slot_deadline [stt_pkg::SLOT_COUNT];
        bit                         slot_once [stt_pkg::SLOT_COUNT];
        logic [stt_pkg::ID_W-1:0]   slot_event [stt_pkg::SLOT_COUNT];
        timer_result_t              due_results [$];
        int                         mismatch_count;

        function new();
            now_ms = '0;
            foreach (slot_used[i]) slot_used[i] = 1'b0;
            mismatch_count = 0;
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        function int periodic_count();
            int n;
            n = 0;
            foreach (slot_used[i]) if (slot_used[i] && !slot_once[i]) n++;
            return n;
        endfunction

        function void add_result(logic [stt_pkg::STATUS_W-1:0] status, int slot,
                                 logic [stt_pkg::ID_W-1:0] id, logic last);
            timer_result_t r;
            r.status   = status;
            r.slot     = slot[stt_pkg::SLOT_W-1:0];
            r.fired_id = id;
            r.last     = last;
            due_results.push_back(r);
        endfunction

        function void note_request(logic cmd, logic [stt_pkg::S_TDATA_W-1:0] data);
            logic [stt_pkg::ID_W-1:0]   id;
            logic [stt_pkg::TIME_W-1:0] per;
            logic [stt_pkg::TIME_W-1:0] off;
            logic                       once;
            int                         free_slot;
            int                         fired;
            id   = data[stt_pkg::ID_W-1:0];
            per  = data[stt_pkg::ID_W +: stt_pkg::TIME_W];
            off  = data[stt_pkg::ID_W+stt_pkg::TIME_W +: stt_pkg::TIME_W];
            once = data[stt_pkg::ID_W+2*stt_pkg::TIME_W];
            if (cmd == stt_pkg::CMD_CREATE) begin
                free_slot = -1;
                if (id != '0) begin
                    for (int i = 0; i < stt_pkg::SLOT_COUNT; i++) begin
                        if (!slot_used[i] && free_slot < 0) free_slot = i;
                    end
                end
                if (free_slot >= 0) begin
                    slot_used[free_slot]     = 1'b1;
                    slot_period[free_slot]   = per;
                    slot_once[free_slot]     = once;
                    slot_event[free_slot]    = id;
                    slot_deadline[free_slot] = now_ms + per + off;
                    add_result(stt_pkg::ST_ACCEPT, free_slot, id, 1'b1);
                end else begin
                    add_result(stt_pkg::ST_REJECT, 0, id, 1'b1);
                end
            end else begin
                now_ms = now_ms + 1;
                fired  = 0;
                for (int i = 0; i < stt_pkg::SLOT_COUNT; i++) begin
                    if (slot_used[i] && slot_deadline[i] <= now_ms) begin
                        add_result(stt_pkg::ST_FIRED, i, slot_event[i], 1'b0);
                        fired++;
                        if (slot_once[i]) slot_used[i] = 1'b0;
                        else slot_deadline[i] = now_ms + slot_period[i];
                    end
                end
                if (fired > 0) due_results[due_results.size()-1].last = 1'b1;
            end
        endfunction

        function void report(string what, timer_result_t want, timer_result_t got);
            mismatch_count++;
            if (mismatch_count <= 10) begin
                $display("%0t %s: expected status %0d slot %0d id 0x%02h last %0d, ",
                         $time, what, want.status, want.slot, want.fired_id, want.last,
                         "got status %0d slot %0d id 0x%02h last %0d",
                         got.status, got.slot, got.fired_id, got.last);
            end
        endfunction

        function void check_result(logic [stt_pkg::STATUS_W-1:0] status,
                                   logic [stt_pkg::M_TDATA_W-1:0] data, logic last);
            timer_result_t want;
            timer_result_t got;
            got.status   = status;
            got.slot     = data[stt_pkg::SLOT_W-1:0];
            got.fired_id = data[stt_pkg::SLOT_W +: stt_pkg::ID_W];
            got.last     = last;
            if (due_results.size() == 0) begin
                report("result with none pending", '0, got);
                return;
            end
            want = due_results.pop_front();
            if (want !== got) report("result differs", want, got);
        endfunction
    endclass

    logic                            aclk;
    logic                            aresetn  = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [stt_pkg::S_TDATA_W-1:0]   s_tdata  = '0;
    logic                            s_tuser  = 1'b0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [stt_pkg::M_TDATA_W-1:0]   m_tdata;
    logic [stt_pkg::STATUS_W-1:0]    m_tuser;
    logic                            m_tlast;

    timer_table_scoreboard_t board = new();
    int                      accepted_requests = 0;
    int                      cycle_count = 0;
    int                      burst_left = 0;

    software_timer_table i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) board.check_result(m_tuser, m_tdata, m_tlast);
            if (s_tvalid && s_tready) begin
                board.note_request(s_tuser, s_tdata);
                accepted_requests++;
            end
        end
    end

    // called at a falling edge, returns at the falling edge after the request is taken
    task automatic send_request(input logic cmd, input logic [stt_pkg::ID_W-1:0] id,
                                input logic [stt_pkg::TIME_W-1:0] per,
                                input logic [stt_pkg::TIME_W-1:0] off,
                                input logic once);
        logic [stt_pkg::S_TDATA_W-1:0] data;
        int                            gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 10);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 10);
        end
        burst_left--;
        data = '0;
        data[stt_pkg::ID_W-1:0]                                  = id;
        data[stt_pkg::ID_W +: stt_pkg::TIME_W]                   = per;
        data[stt_pkg::ID_W+stt_pkg::TIME_W +: stt_pkg::TIME_W]   = off;
        data[stt_pkg::ID_W+2*stt_pkg::TIME_W]                    = once;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= data;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic send_tick();
        send_request(stt_pkg::CMD_TICK, stt_pkg::ID_W'($urandom), $urandom, $urandom,
                     1'($urandom));
    endtask

    // receiver: rotating stall pattern plus one long hold-off
    initial begin
        int  phase_cycle;
        bit  hold_done;
        phase_cycle = 0;
        hold_done   = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (!hold_done && accepted_requests >= 120) begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end else begin
                phase_cycle++;
                case ((phase_cycle / 48) % 4)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 9) < 7);
                    2: m_tready <= ($urandom_range(0, 9) < 2);
                    default: m_tready <= (phase_cycle % 3 != 0);
                endcase
            end
        end
    end

    initial begin
        logic [stt_pkg::ID_W-1:0]   fill_ids [8] = '{8'h01, 8'hFF, 8'h80, 8'h7F,
                                                     8'h55, 8'hAA, 8'h0F, 8'hF0};
        logic [stt_pkg::ID_W-1:0]   id;
        logic [stt_pkg::TIME_W-1:0] per;
        logic [stt_pkg::TIME_W-1:0] off;
        logic                       once;
        int                         pick;

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // event id 0 is refused
        send_request(stt_pkg::CMD_CREATE, 8'h00, '1, '1, 1'b1);
        // fill every slot with one-shots due on the next tick
        for (int k = 0; k < 8; k++) begin
            send_request(stt_pkg::CMD_CREATE, fill_ids[k], '0, 32'd1, 1'b1);
        end
        // table full
        send_request(stt_pkg::CMD_CREATE, 8'h33, 32'h0000_00FF, 32'h8000_0000, 1'b0);
        send_tick();
        // nothing due
        send_tick();
        // periodic with period 0 fires on every tick
        send_request(stt_pkg::CMD_CREATE, 8'h5A, '0, '0, 1'b0);
        send_tick();
        send_tick();
        // first deadline wraps past 2^32 and is due at once
        send_request(stt_pkg::CMD_CREATE, 8'hC3, '1, '1, 1'b1);
        send_tick();
        send_request(stt_pkg::CMD_CREATE, 8'h3C, 32'd2, '0, 1'b0);
        send_request(stt_pkg::CMD_CREATE, 8'h96, 32'hFFFF_FFF0, 32'h0000_0013, 1'b1);
        repeat (4) send_tick();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                send_tick();
            end else if (pick < 75) begin
                id   = stt_pkg::ID_W'($urandom_range(1, 255));
                per  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 60) : $urandom_range(0, 15);
                off  = $urandom_range(0, 10);
                once = (board.periodic_count() >= 4) ? 1'b1 : ($urandom_range(0, 3) != 0);
                send_request(stt_pkg::CMD_CREATE, id, per, off, once);
            end else if (pick < 88) begin
                // sum of period and offset wraps to a near deadline
                id  = stt_pkg::ID_W'($urandom_range(1, 255));
                per = $urandom;
                off = $urandom_range(0, 20) - per;
                send_request(stt_pkg::CMD_CREATE, id, per, off, 1'b1);
            end else begin
                send_request(stt_pkg::CMD_CREATE, 8'h00, $urandom, $urandom, 1'($urandom));
            end
        end

        s_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge aclk);
        repeat (4 * (stt_pkg::SLOT_COUNT + 2)) @(posedge aclk);

        if (board.mismatch_count == 0 && board.pending() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
